FILE: sv/nfb_pkg.sv
// nfb_pkg: shared constants, types and the crc byte step for the nav frame builder
// used by nfb_crc16 and nav_frame_builder_crc16; depends on nothing else
package nfb_pkg;

  localparam int unsigned FRAME_LEN = 17;
  localparam int unsigned BODY_LEN  = 13;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);
  localparam int unsigned BODY_W    = $clog2(BODY_LEN);

  // byte positions inside the frame
  localparam logic [POS_W-1:0] POS_SYNC_FIRST  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC_SECOND = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY_FIRST  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_BODY_LAST   = POS_W'(14);
  localparam logic [POS_W-1:0] POS_CRC_LOW     = POS_W'(15);
  localparam logic [POS_W-1:0] POS_CRC_HIGH    = POS_W'(16);

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef struct packed {
    logic init;
    logic en;
  } crc_ctl_t;

  // one byte of crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/nfb_crc16.sv
// nfb_crc16: running crc-16/ccitt-false register, one byte per cycle while en is high
// depends on nfb_pkg
module nfb_crc16 (
  input  logic              clk,
  input  nfb_pkg::crc_ctl_t ctl,
  input  logic [7:0]        data,
  output logic [15:0]       crc
);

  logic [15:0] crc_next;

  always_comb begin
    if (ctl.init) begin
      crc_next = nfb_pkg::CRC_INIT;
    end else if (ctl.en) begin
      crc_next = nfb_pkg::crc_byte(crc, data);
    end else begin
      crc_next = crc;
    end
  end

  // init is raised on every frame before any use, so no reset needed
  always_ff @(posedge clk) begin
    crc <= crc_next;
  end

endmodule

FILE: sv/nav_frame_builder_crc16.sv
// nav_frame_builder_crc16: top level, turns one nav command into a 17-byte frame
// depends on nfb_pkg and nfb_crc16
//
// usage
//   command channel: a transaction is taken at a rising edge with start high and
//   busy low; frame_id and the three raw float words are captured then
//   result channel: one frame byte per cycle on tx_byte, marked by valid;
//   last_byte is high with the seventeenth byte (crc high byte)
//   frame: 0xaa 0x55 id fwd[4] yaw[4] depth[4] crc_lo crc_hi, words little-endian
//   crc: ccitt-false (poly 0x1021, init 0xffff) over id and the twelve word bytes
//   latency: first byte is valid the cycle after the command is taken
//   throughput: each command takes one full frame on the byte-wide result channel;
//   busy drops during the last byte so the next command is taken then and its
//   first byte follows the last byte of the previous frame with no gap
//   the crc is built one byte per cycle as the body bytes go out, so the crc
//   bytes are ready by the time they are sent
//   reset: no frame in flight, valid and busy low, next command taken at once
//   the receiver has no way to stall, so every byte is shown for one cycle only
module nav_frame_builder_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  frame_id,
  input  logic [31:0] forward_step,
  input  logic [31:0] yaw_step,
  input  logic [31:0] depth_target,
  output logic        valid,
  output logic [7:0]  tx_byte,
  output logic        last_byte
);

  // frame position counter and active flag
  logic [nfb_pkg::POS_W-1:0] pos;
  logic [nfb_pkg::POS_W-1:0] pos_next;
  logic                      valid_next;
  logic                      take;

  // captured command: the 13 crc-covered bytes in send order
  logic [7:0] body [nfb_pkg::BODY_LEN];
  logic [nfb_pkg::BODY_W-1:0] body_idx;

  logic [15:0]       crc;
  nfb_pkg::crc_ctl_t crc_ctl;

  // ready again while the last byte goes out
  assign busy = valid && (pos != nfb_pkg::POS_CRC_HIGH);
  assign take = start && !busy;

  always_comb begin
    valid_next = valid;
    pos_next   = pos;
    if (take) begin
      valid_next = 1'b1;
      pos_next   = nfb_pkg::POS_SYNC_FIRST;
    end else if (valid) begin
      if (pos == nfb_pkg::POS_CRC_HIGH) begin
        valid_next = 1'b0;
      end else begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= nfb_pkg::POS_SYNC_FIRST;
    end else begin
      valid <= valid_next;
      pos   <= pos_next;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      body[0]  <= frame_id;
      body[1]  <= forward_step[7:0];
      body[2]  <= forward_step[15:8];
      body[3]  <= forward_step[23:16];
      body[4]  <= forward_step[31:24];
      body[5]  <= yaw_step[7:0];
      body[6]  <= yaw_step[15:8];
      body[7]  <= yaw_step[23:16];
      body[8]  <= yaw_step[31:24];
      body[9]  <= depth_target[7:0];
      body[10] <= depth_target[15:8];
      body[11] <= depth_target[23:16];
      body[12] <= depth_target[31:24];
    end
  end

  // body bytes start right after the two sync bytes
  assign body_idx = nfb_pkg::BODY_W'(pos - nfb_pkg::POS_BODY_FIRST);

  // byte select for the current frame position
  always_comb begin
    case (pos)
      nfb_pkg::POS_SYNC_FIRST:  tx_byte = nfb_pkg::SYNC_FIRST;
      nfb_pkg::POS_SYNC_SECOND: tx_byte = nfb_pkg::SYNC_SECOND;
      nfb_pkg::POS_CRC_LOW:     tx_byte = crc[7:0];
      nfb_pkg::POS_CRC_HIGH:    tx_byte = crc[15:8];
      default:                  tx_byte = body[body_idx];
    endcase
  end

  assign last_byte = valid && (pos == nfb_pkg::POS_CRC_HIGH);

  // crc restarts on the first sync byte and folds in each body byte as it is sent
  assign crc_ctl.init = valid && (pos == nfb_pkg::POS_SYNC_FIRST);
  assign crc_ctl.en   = valid && (pos >= nfb_pkg::POS_BODY_FIRST)
                              && (pos <= nfb_pkg::POS_BODY_LAST);

  nfb_crc16 u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (tx_byte),
    .crc  (crc)
  );

endmodule
